@@ hw/rtl/hsc_pkg.sv @@
// ---------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for the HSV shift and contrast pixel pipeline.
// ---------------------------------------------------------------------------
package hsc_pkg;

  typedef struct packed {
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       in_target;
  } in_item_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic signed [8:0] hue_offset;
    logic signed [7:0] saturation_shift;
    logic signed [7:0] brightness_shift;
    logic signed [7:0] contrast_shift;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_HUE_OFFSET       = 2'd0,
    CFG_SATURATION_SHIFT = 2'd1,
    CFG_BRIGHTNESS_SHIFT = 2'd2,
    CFG_CONTRAST_SHIFT   = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_W = 9;

  // sideband that follows every item down the pipe
  typedef struct packed {
    out_item_t pix;
    logic      pass;
  } px_side_t;

  typedef struct packed {
    px_side_t   px;
    logic       grey;
    logic [7:0] val;
  } div_side_t;

  // divider geometry
  localparam int DIV_STG   = 4;
  localparam int DIV_NUM_W = 25;
  localparam int HUE_DEN_W = 16;
  localparam int HUE_QW    = 12;
  localparam int SAT_DEN_W = 9;
  localparam int SAT_QW    = 16;

  localparam int FAC_W   = 23;
  localparam int LATENCY = 15;

endpackage

@@ hw/rtl/hsc_div.sv @@
// ---------------------------------------------------------------------------
// hsc_div
// Pipelined restoring dividers for hue and saturation, a few quotient bits
// per stage, with the item sideband alongside.
// ---------------------------------------------------------------------------
module hsc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  hsc_pkg::div_side_t               in_side,
  input  logic [hsc_pkg::DIV_NUM_W-1:0]    hue_num,
  input  logic [hsc_pkg::HUE_DEN_W-1:0]    hue_den,
  input  logic [hsc_pkg::DIV_NUM_W-1:0]    sat_num,
  input  logic [hsc_pkg::SAT_DEN_W-1:0]    sat_den,
  output logic                             out_valid,
  output hsc_pkg::div_side_t               out_side,
  output logic [8:0]                       hue_q,
  output logic [hsc_pkg::SAT_QW-1:0]       sat_q
);
  import hsc_pkg::*;

  localparam int H_SPS = HUE_QW / DIV_STG;
  localparam int S_SPS = SAT_QW / DIV_STG;
  localparam int HCW   = DIV_NUM_W + HUE_QW;
  localparam int SCW   = DIV_NUM_W + SAT_QW;

  logic [DIV_STG:0]       vld_r;
  div_side_t              side_r    [DIV_STG+1];
  logic [DIV_NUM_W-1:0]   h_rem_r   [DIV_STG+1];
  logic [DIV_NUM_W-1:0]   h_rem_nxt [DIV_STG+1];
  logic [HUE_DEN_W-1:0]   h_den_r   [DIV_STG+1];
  logic [HUE_QW-1:0]      h_q_r     [DIV_STG+1];
  logic [HUE_QW-1:0]      h_q_nxt   [DIV_STG+1];
  logic [DIV_NUM_W-1:0]   s_rem_r   [DIV_STG+1];
  logic [DIV_NUM_W-1:0]   s_rem_nxt [DIV_STG+1];
  logic [SAT_DEN_W-1:0]   s_den_r   [DIV_STG+1];
  logic [SAT_QW-1:0]      s_q_r     [DIV_STG+1];
  logic [SAT_QW-1:0]      s_q_nxt   [DIV_STG+1];

  assign h_rem_nxt[0] = hue_num;
  assign h_q_nxt[0]   = '0;
  assign s_rem_nxt[0] = sat_num;
  assign s_q_nxt[0]   = '0;

  for (genvar j = 1; j <= DIV_STG; j++) begin : g_stg
    always_comb begin : c_hue
      logic [HCW-1:0]    r;
      logic [HCW-1:0]    sh;
      logic [HUE_QW-1:0] q;
      r = HCW'(h_rem_r[j-1]);
      q = h_q_r[j-1];
      for (int k = 0; k < H_SPS; k++) begin
        sh = HCW'(h_den_r[j-1]) << (HUE_QW - 1 - ((j - 1) * H_SPS + k));
        if (r >= sh) begin
          r = r - sh;
          q[HUE_QW - 1 - ((j - 1) * H_SPS + k)] = 1'b1;
        end
      end
      h_rem_nxt[j] = r[DIV_NUM_W-1:0];
      h_q_nxt[j]   = q;
    end

    always_comb begin : c_sat
      logic [SCW-1:0]    r;
      logic [SCW-1:0]    sh;
      logic [SAT_QW-1:0] q;
      r = SCW'(s_rem_r[j-1]);
      q = s_q_r[j-1];
      for (int k = 0; k < S_SPS; k++) begin
        sh = SCW'(s_den_r[j-1]) << (SAT_QW - 1 - ((j - 1) * S_SPS + k));
        if (r >= sh) begin
          r = r - sh;
          q[SAT_QW - 1 - ((j - 1) * S_SPS + k)] = 1'b1;
        end
      end
      s_rem_nxt[j] = r[DIV_NUM_W-1:0];
      s_q_nxt[j]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0]  <= in_side;
    h_den_r[0] <= hue_den;
    s_den_r[0] <= sat_den;
    for (int j = 0; j <= DIV_STG; j++) begin
      h_rem_r[j] <= h_rem_nxt[j];
      h_q_r[j]   <= h_q_nxt[j];
      s_rem_r[j] <= s_rem_nxt[j];
      s_q_r[j]   <= s_q_nxt[j];
    end
    for (int j = 1; j <= DIV_STG; j++) begin
      side_r[j]  <= side_r[j-1];
      h_den_r[j] <= h_den_r[j-1];
      s_den_r[j] <= s_den_r[j-1];
    end
  end

  assign out_valid = vld_r[DIV_STG];
  assign out_side  = side_r[DIV_STG];
  assign hue_q     = h_q_r[DIV_STG][8:0];
  assign sat_q     = s_q_r[DIV_STG];

endmodule

@@ hw/rtl/hsc_front.sv @@
// ---------------------------------------------------------------------------
// hsc_front
// Max/min and hue sector of the pixel, then the dividend and divisor for
// hue and saturation.
// ---------------------------------------------------------------------------
module hsc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  hsc_pkg::in_item_t              in_item,
  input  hsc_pkg::cfg_t                  cfg,
  output logic                           div_valid,
  output hsc_pkg::div_side_t             div_side,
  output logic [hsc_pkg::DIV_NUM_W-1:0]  hue_num,
  output logic [hsc_pkg::HUE_DEN_W-1:0]  hue_den,
  output logic [hsc_pkg::DIV_NUM_W-1:0]  sat_num,
  output logic [hsc_pkg::SAT_DEN_W-1:0]  sat_den
);
  import hsc_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  logic [7:0] mx, mn;
  sector_t    sec;
  logic       pass;

  logic       vld_r;
  in_item_t   pix_r;
  logic [7:0] mx_r, d_r;
  sector_t    sec_r;
  logic       pass_r;

  logic signed [11:0] nt;
  logic signed [11:0] d12;
  logic [10:0]        n;

  always_comb begin
    mx = in_item.red_in;
    if (in_item.green_in > mx) mx = in_item.green_in;
    if (in_item.blue_in > mx)  mx = in_item.blue_in;
    mn = in_item.red_in;
    if (in_item.green_in < mn) mn = in_item.green_in;
    if (in_item.blue_in < mn)  mn = in_item.blue_in;
    // red wins ties, then green
    if (mx == in_item.red_in)        sec = SEC_RED;
    else if (mx == in_item.green_in) sec = SEC_GREEN;
    else                             sec = SEC_BLUE;
    pass = (cfg == '0) || !in_item.in_target || (in_item.alpha_in == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= in_item;
    mx_r   <= mx;
    d_r    <= mx - mn;
    sec_r  <= sec;
    pass_r <= pass;
  end

  // hue numerator in sectors times d, wrapped for the red sector
  always_comb begin
    d12 = $signed({4'b0, d_r});
    case (sec_r)
      SEC_RED: begin
        nt = $signed({4'b0, pix_r.green_in}) - $signed({4'b0, pix_r.blue_in});
        if (nt < 0) nt = nt + 12'sd6 * d12;
      end
      SEC_GREEN: nt = 12'sd2 * d12 + $signed({4'b0, pix_r.blue_in})
                      - $signed({4'b0, pix_r.red_in});
      SEC_BLUE:  nt = 12'sd4 * d12 + $signed({4'b0, pix_r.red_in})
                      - $signed({4'b0, pix_r.green_in});
      default:   nt = '0;
    endcase
    n = nt[10:0];
  end

  // hue = floor((12000 n + d) / (200 d)); s16 = floor((131070 d + M) / (2 M))
  assign hue_num = DIV_NUM_W'(n) * DIV_NUM_W'(12000) + DIV_NUM_W'(d_r);
  assign hue_den = HUE_DEN_W'(d_r) * HUE_DEN_W'(200);
  assign sat_num = DIV_NUM_W'(d_r) * DIV_NUM_W'(131070) + DIV_NUM_W'(mx_r);
  assign sat_den = {mx_r, 1'b0};

  assign div_valid = vld_r;
  always_comb begin
    div_side.px.pix.alpha_out = pix_r.alpha_in;
    div_side.px.pix.red_out   = pix_r.red_in;
    div_side.px.pix.green_out = pix_r.green_in;
    div_side.px.pix.blue_out  = pix_r.blue_in;
    div_side.px.pass          = pass_r;
    div_side.grey             = (d_r == 8'd0);
    div_side.val              = mx_r;
  end

endmodule

@@ hw/rtl/hsc_adjust.sv @@
// ---------------------------------------------------------------------------
// hsc_adjust
// Saturation to 8 bits, hue rotation, and the percent shifts of saturation
// and value.
// ---------------------------------------------------------------------------
module hsc_adjust (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hsc_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  input  hsc_pkg::div_side_t       in_side,
  input  logic [8:0]               hue_q,
  input  logic [hsc_pkg::SAT_QW-1:0] sat_q,
  output logic                     out_valid,
  output hsc_pkg::px_side_t        out_side,
  output logic [8:0]               hue,
  output logic [7:0]               sat,
  output logic [7:0]               val
);
  import hsc_pkg::*;

  // floor(n / 200) for 16-bit n
  localparam logic [32:0] RCP_200 = 33'd83887;

  function automatic logic [15:0] shift_num(logic [7:0] x, logic signed [7:0] sh);
    logic [7:0]  mag;
    logic [7:0]  base;
    logic [15:0] prod;
    mag  = sh[7] ? 8'(-sh) : 8'(sh);
    base = sh[7] ? x : 8'(8'd255 - x);
    prod = 16'(base) * 16'(mag);
    return {prod[14:0], 1'b0} + 16'd100;
  endfunction

  function automatic logic [7:0] shift_apply(logic [7:0] x, logic [15:0] num,
                                             logic signed [7:0] sh);
    logic [32:0]        prod;
    logic [8:0]         q;
    logic [9:0]         up;
    logic signed [10:0] dn;
    logic [7:0]         res;
    prod = 33'(num) * RCP_200;
    q    = prod[32:24];
    up   = 10'(x) + 10'(q);
    dn   = $signed({3'b0, x}) - $signed({2'b0, q});
    if (sh == 8'sd0)   res = x;
    else if (sh[7])    res = (dn < 0) ? 8'd0 : dn[7:0];
    else               res = (up > 10'd255) ? 8'd255 : up[7:0];
    return res;
  endfunction

  // stage A, B and C registers, then stage A logic
  logic [2:0]  vld_r;
  px_side_t    side_a_r, side_b_r, side_c_r;
  logic [8:0]  hue_a_r, hue_b_r, hue_c_r;
  logic [7:0]  sat_a_r, val_a_r, sat_b_r, val_b_r, sat_c_r, val_c_r;
  logic [15:0] sat_n_r, val_n_r;

  logic [16:0]        s_tmp;
  logic [8:0]         hue_base;
  logic signed [10:0] hsum;
  logic [8:0]         hue_nxt;
  logic [7:0]         sat_nxt;

  always_comb begin
    s_tmp    = 17'(sat_q) - 17'(sat_q[15:8]) + 17'd128;
    sat_nxt  = in_side.grey ? 8'd0 : s_tmp[15:8];
    // grey has no hue: it counts as red
    hue_base = in_side.grey ? 9'd0 : hue_q;
    hsum     = $signed({2'b0, hue_base}) + 11'(cfg.hue_offset);
    if (hsum < 0)             hsum = hsum + 11'sd360;
    else if (hsum >= 11'sd360) hsum = hsum - 11'sd360;
    hue_nxt  = (cfg.hue_offset == 9'sd0) ? hue_base : hsum[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_a_r <= in_side.px;
    hue_a_r  <= hue_nxt;
    sat_a_r  <= sat_nxt;
    val_a_r  <= in_side.val;

    side_b_r <= side_a_r;
    hue_b_r  <= hue_a_r;
    sat_b_r  <= sat_a_r;
    val_b_r  <= val_a_r;
    sat_n_r  <= shift_num(sat_a_r, cfg.saturation_shift);
    val_n_r  <= shift_num(val_a_r, cfg.brightness_shift);

    side_c_r <= side_b_r;
    hue_c_r  <= hue_b_r;
    sat_c_r  <= shift_apply(sat_b_r, sat_n_r, cfg.saturation_shift);
    val_c_r  <= shift_apply(val_b_r, val_n_r, cfg.brightness_shift);
  end

  assign out_valid = vld_r[2];
  assign out_side  = side_c_r;
  assign hue       = hue_c_r;
  assign sat       = sat_c_r;
  assign val       = val_c_r;

endmodule

@@ hw/rtl/hsc_hsv2rgb.sv @@
// ---------------------------------------------------------------------------
// hsc_hsv2rgb
// HSV back to RGB: sector weights, 257*V*K scaling, rounding to 8 bits.
// ---------------------------------------------------------------------------
module hsc_hsv2rgb (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  hsc_pkg::px_side_t in_side,
  input  logic [8:0]        hue,
  input  logic [7:0]        sat,
  input  logic [7:0]        val,
  output logic              out_valid,
  output hsc_pkg::px_side_t out_side,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);
  import hsc_pkg::*;

  // floor(n / 3825) for n below 2**28
  localparam longint unsigned RCP_3825 = ((64'd1 << 41) + 64'd3824) / 64'd3825;

  function automatic logic [29:0] scale(logic [7:0] v, logic [13:0] k);
    logic [21:0] vk;
    vk = 22'(v) * 22'(k);
    return {vk, 8'b0} + 30'(vk);
  endfunction

  function automatic logic [15:0] div30600(logic [29:0] n);
    logic [30:0] n2;
    logic [57:0] prod;
    n2   = {n, 1'b0} + 31'd15300;
    prod = 58'(n2[30:3]) * 58'(RCP_3825);
    return prod[56:41];
  endfunction

  function automatic logic [7:0] to8(logic [15:0] c16);
    logic [16:0] t;
    t = 17'(c16) - 17'(c16[15:8]) + 17'd128;
    return t[15:8];
  endfunction

  logic [3:0] vld_r;
  px_side_t   side_d_r, side_e_r, side_f_r, side_g_r;
  logic [2:0] i_d_r, i_e_r, i_f_r;
  logic [7:0] v_d_r, v_e_r, v_f_r;
  logic       sz_d_r, sz_e_r, sz_f_r;
  logic [13:0] kp_r, kq_r, kt_r;
  logic [29:0] np_r, nq_r, nt_r;
  logic [15:0] cp_r, cq_r, ct_r;
  logic [7:0]  red_r, green_r, blue_r;

  logic [2:0]  i_nxt;
  logic [8:0]  base;
  logic [5:0]  f;
  logic [7:0]  p8, q8, t8;

  always_comb begin
    if (hue >= 9'd300)      begin i_nxt = 3'd5; base = 9'd300; end
    else if (hue >= 9'd240) begin i_nxt = 3'd4; base = 9'd240; end
    else if (hue >= 9'd180) begin i_nxt = 3'd3; base = 9'd180; end
    else if (hue >= 9'd120) begin i_nxt = 3'd2; base = 9'd120; end
    else if (hue >= 9'd60)  begin i_nxt = 3'd1; base = 9'd60;  end
    else                    begin i_nxt = 3'd0; base = 9'd0;   end
    f = 6'(hue - base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_d_r <= in_side;
    i_d_r    <= i_nxt;
    v_d_r    <= val;
    sz_d_r   <= (sat == 8'd0);
    kp_r     <= 14'd60 * 14'(8'd255 - sat);
    kq_r     <= 14'd15300 - 14'(sat) * 14'(f);
    kt_r     <= 14'd15300 - 14'(sat) * 14'(7'd60 - 7'(f));

    side_e_r <= side_d_r;
    i_e_r    <= i_d_r;
    v_e_r    <= v_d_r;
    sz_e_r   <= sz_d_r;
    np_r     <= scale(v_d_r, kp_r);
    nq_r     <= scale(v_d_r, kq_r);
    nt_r     <= scale(v_d_r, kt_r);

    side_f_r <= side_e_r;
    i_f_r    <= i_e_r;
    v_f_r    <= v_e_r;
    sz_f_r   <= sz_e_r;
    cp_r     <= div30600(np_r);
    cq_r     <= div30600(nq_r);
    ct_r     <= div30600(nt_r);

    side_g_r <= side_f_r;
  end

  always_ff @(posedge clk) begin
    if (sz_f_r) begin
      red_r <= v_f_r; green_r <= v_f_r; blue_r <= v_f_r;
    end else begin
      case (i_f_r)
        3'd0:    begin red_r <= v_f_r; green_r <= t8;    blue_r <= p8;    end
        3'd1:    begin red_r <= q8;    green_r <= v_f_r; blue_r <= p8;    end
        3'd2:    begin red_r <= p8;    green_r <= v_f_r; blue_r <= t8;    end
        3'd3:    begin red_r <= p8;    green_r <= q8;    blue_r <= v_f_r; end
        3'd4:    begin red_r <= t8;    green_r <= p8;    blue_r <= v_f_r; end
        default: begin red_r <= v_f_r; green_r <= p8;    blue_r <= q8;    end
      endcase
    end
  end

  assign p8 = to8(cp_r);
  assign q8 = to8(cq_r);
  assign t8 = to8(ct_r);

  assign out_valid = vld_r[3];
  assign out_side  = side_g_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

@@ hw/rtl/hsc_contrast.sv @@
// ---------------------------------------------------------------------------
// hsc_contrast
// Contrast stretch about level 128 with a factor ROM in Q7.16, and the
// final pass-through select.
// ---------------------------------------------------------------------------
module hsc_contrast (
  input  logic              clk,
  input  logic              rst_n,
  input  hsc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  hsc_pkg::px_side_t in_side,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  output hsc_pkg::out_item_t out_item
);
  import hsc_pkg::*;

  logic [FAC_W-1:0] rom [256];

  for (genvar s = 0; s < 256; s++) begin : g_rom
    localparam longint SV  = (s < 128) ? longint'(s) : longint'(s) - 256;
    localparam longint CR  = 255 * SV;
    localparam longint CC  = (CR < -25500) ? -25500 : ((CR > 25400) ? 25400 : CR);
    localparam longint NUM = 64'sd65536 * 259 * (CC + 25500);
    localparam longint DEN = 255 * (25900 - CC);
    localparam longint FAC = (2 * NUM + DEN) / (2 * DEN);
    assign rom[s] = FAC_W'(FAC);
  end

  function automatic logic signed [33:0] lift(logic [FAC_W-1:0] fac, logic [7:0] x);
    logic signed [9:0]  xc;
    logic signed [33:0] f34;
    logic signed [33:0] x34;
    xc  = $signed({2'b0, x}) - 10'sd128;
    f34 = $signed({{(34 - FAC_W){1'b0}}, fac});
    x34 = 34'(xc);
    return f34 * x34 + 34'sd8388608;
  endfunction

  function automatic logic [7:0] squash(logic signed [33:0] y);
    logic signed [33:0] r;
    logic [7:0]         res;
    r = y + 34'sd32768;
    if (y <= 0)                       res = 8'd0;
    else if (r[33:16] > 18'd255)      res = 8'd255;
    else                              res = r[23:16];
    return res;
  endfunction

  logic [FAC_W-1:0]  fac;
  logic [1:0]        vld_r;
  px_side_t          side_r;
  logic [7:0]        red_r, green_r, blue_r;
  logic signed [33:0] yr_r, yg_r, yb_r;
  out_item_t         out_r;

  assign fac = rom[$unsigned(cfg.contrast_shift)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r  <= in_side;
    red_r   <= red;
    green_r <= green;
    blue_r  <= blue;
    yr_r    <= lift(fac, red);
    yg_r    <= lift(fac, green);
    yb_r    <= lift(fac, blue);

    if (side_r.pass) begin
      out_r <= side_r.pix;
    end else if (cfg.contrast_shift == 8'sd0) begin
      out_r <= {side_r.pix.alpha_out, red_r, green_r, blue_r};
    end else begin
      out_r <= {side_r.pix.alpha_out, squash(yr_r), squash(yg_r), squash(yb_r)};
    end
  end

  assign out_valid = vld_r[1];
  assign out_item  = out_r;

endmodule

@@ hw/rtl/hsv_shift_contrast_pixel.sv @@
// ---------------------------------------------------------------------------
// hsv_shift_contrast_pixel
// ARGB pixel through RGB->HSV, hue/saturation/value shifts, HSV->RGB and a
// contrast stretch.
//
//   channel   ports                                   handshake
//   input     start, busy, in_data                    start & !busy
//   result    out_valid, out_data                     one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  valid & ready
//
// One item per clock, every clock; busy and cfg_ready are constant.
// Pipeline order: front, divider (input register plus four quotient stages),
// shifts (stages A to C), HSV to RGB (stages D to G), contrast.
// Synchronous reset empties the pipe and clears the valid bits and the
// adjustment registers to zero.
// Nothing stalls: results are strobed and must be taken when shown.
// ---------------------------------------------------------------------------
module hsv_shift_contrast_pixel (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  hsc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  output hsc_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  hsc_pkg::cfg_idx_t               cfg_index,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hsc_pkg::*;

  cfg_t cfg_r;

  logic                 acc;
  logic                 f_vld, d_vld, a_vld, h_vld;
  div_side_t            f_side, d_side;
  px_side_t             a_side, h_side;
  logic [DIV_NUM_W-1:0] hue_num, sat_num;
  logic [HUE_DEN_W-1:0] hue_den;
  logic [SAT_DEN_W-1:0] sat_den;
  logic [8:0]           hue_q, a_hue;
  logic [SAT_QW-1:0]    sat_q;
  logic [7:0]           a_sat, a_val, h_red, h_green, h_blue;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HUE_OFFSET:       cfg_r.hue_offset       <= cfg_data;
        CFG_SATURATION_SHIFT: cfg_r.saturation_shift <= cfg_data[7:0];
        CFG_BRIGHTNESS_SHIFT: cfg_r.brightness_shift <= cfg_data[7:0];
        CFG_CONTRAST_SHIFT:   cfg_r.contrast_shift   <= cfg_data[7:0];
        default:              cfg_r <= cfg_r;
      endcase
    end
  end

  hsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .div_valid (f_vld),
    .div_side  (f_side),
    .hue_num   (hue_num),
    .hue_den   (hue_den),
    .sat_num   (sat_num),
    .sat_den   (sat_den)
  );

  hsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld),
    .in_side   (f_side),
    .hue_num   (hue_num),
    .hue_den   (hue_den),
    .sat_num   (sat_num),
    .sat_den   (sat_den),
    .out_valid (d_vld),
    .out_side  (d_side),
    .hue_q     (hue_q),
    .sat_q     (sat_q)
  );

  hsc_adjust u_adjust (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (d_vld),
    .in_side   (d_side),
    .hue_q     (hue_q),
    .sat_q     (sat_q),
    .out_valid (a_vld),
    .out_side  (a_side),
    .hue       (a_hue),
    .sat       (a_sat),
    .val       (a_val)
  );

  hsc_hsv2rgb u_hsv2rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_vld),
    .in_side   (a_side),
    .hue       (a_hue),
    .sat       (a_sat),
    .val       (a_val),
    .out_valid (h_vld),
    .out_side  (h_side),
    .red       (h_red),
    .green     (h_green),
    .blue      (h_blue)
  );

  hsc_contrast u_contrast (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (h_vld),
    .in_side   (h_side),
    .red       (h_red),
    .green     (h_green),
    .blue      (h_blue),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  // every result traces back to an item taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LATENCY))
    else $error("result without matching item");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.alpha_out == $past(in_data.alpha_in, LATENCY))
    else $error("alpha altered");

  a_untargeted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(in_data.in_target, LATENCY) |->
      out_data.red_out == $past(in_data.red_in, LATENCY) &&
      out_data.green_out == $past(in_data.green_in, LATENCY) &&
      out_data.blue_out == $past(in_data.blue_in, LATENCY))
    else $error("untargeted pixel altered");

  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule
